[hdl/sfe_pkg.sv]
package sfe_pkg;

	// default widths
	localparam int FRAME_BITS_DEF     = 29;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	// pcm sample width and packed stereo word width
	localparam int SAMPLE_W = 16;
	localparam int WORD_W   = 2 * SAMPLE_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FADE_IN  = 2'd0,
		CFG_FADE_OUT = 2'd1,
		CFG_CLIP     = 2'd2
	} cfg_idx_t;

endpackage

[hdl/stereo_linear_fade_envelope.sv]
// sequence: an accepted word passes prep, then a divide and a multiply pass per active ramp
// (two pairs where both ramps overlap, none outside both ramps), then the finish step
// throughput: one frame at a time; the next word is taken once the result sits in the
// output register, set by the bit-serial divider and shift-add multiplier (one bit a cycle)
// reset: arst_n clears the frame counter, the ramp registers, the sequencer and the
// output valid flag asynchronously
module stereo_linear_fade_envelope #(
	parameter int FRAME_BITS     = sfe_pkg::FRAME_BITS_DEF,
	parameter int GAIN_FRAC_BITS = sfe_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAME_BITS-1:0]        cfg_data,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sfe_pkg::WORD_W-1:0]   s_tdata,   // left_in [15:0], right_in [31:16]
	// output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sfe_pkg::WORD_W-1:0]   m_tdata    // left_out [15:0], right_out [31:16]
);

	localparam int SW    = sfe_pkg::SAMPLE_W;
	localparam int GW    = GAIN_FRAC_BITS + 1;          // gain is q1.frac, up to 1.0
	localparam int PW    = SW + GW;                     // full product width
	localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	// ramp registers
	logic [FRAME_BITS-1:0] fade_in_q, fade_out_q, clip_q;
	logic [FRAME_BITS-1:0] frame_q;

	// working samples
	logic signed [SW-1:0] left_q, right_q;

	// per-frame decisions
	logic                  phase_out_q;    // 0: fade-in pass, 1: fade-out pass
	logic                  do_out_q;
	logic [FRAME_BITS-1:0] diff_q;         // frames left to clip end

	// shared divider and multiplier
	logic [FRAME_BITS:0]   rem_q;
	logic [FRAME_BITS-1:0] den_q;
	logic [GW-1:0]         gain_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SW-1:0]         mag_l_q, mag_r_q;
	logic                  neg_l_q, neg_r_q;
	logic [PW-1:0]         acc_l_q, acc_r_q;

	// output register
	logic                  out_valid_q;
	logic [sfe_pkg::WORD_W-1:0] out_data_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	logic s_acc, m_free, last_bit;
	assign s_acc    = s_tvalid && s_tready;
	assign m_free   = !out_valid_q || m_tready;
	assign last_bit = (cnt_q == CNT_W'(GAIN_FRAC_BITS));

	// frame position checks, used in the prep cycle
	logic                  in_clip, do_in, do_out;
	logic [FRAME_BITS-1:0] diff;
	logic [FRAME_BITS:0]   nxt;
	always_comb begin
		in_clip = (frame_q < clip_q);
		diff    = clip_q - frame_q;
		do_in   = in_clip && (fade_in_q != '0) && (frame_q < fade_in_q);
		do_out  = in_clip && (fade_out_q != '0) && (diff <= fade_out_q);
		nxt     = {1'b0, frame_q} + {{FRAME_BITS{1'b0}}, 1'b1};
	end

	// restoring divide step: one quotient bit, msb first
	logic                  div_ge;
	logic [FRAME_BITS:0]   div_sub;
	logic [FRAME_BITS-1:0] div_rem;
	always_comb begin
		div_ge  = (rem_q >= {1'b0, den_q});
		div_sub = rem_q - {1'b0, den_q};
		div_rem = div_ge ? div_sub[FRAME_BITS-1:0] : rem_q[FRAME_BITS-1:0];
	end

	// shift-add multiply step: gain bits lsb first, both channels together
	logic [SW:0]           top_l, top_r;
	logic [PW-1:0]         acc_l_nx, acc_r_nx;
	logic [SW-1:0]         res_l_mag, res_r_mag;
	logic [SW-1:0]         res_l, res_r;
	always_comb begin
		top_l     = {1'b0, acc_l_q[PW-1 -: SW]} + (gain_q[0] ? {1'b0, mag_l_q} : '0);
		top_r     = {1'b0, acc_r_q[PW-1 -: SW]} + (gain_q[0] ? {1'b0, mag_r_q} : '0);
		acc_l_nx  = {top_l, acc_l_q[PW-SW-1:1]};
		acc_r_nx  = {top_r, acc_r_q[PW-SW-1:1]};
		// product >> frac never exceeds the input magnitude
		res_l_mag = acc_l_nx[GAIN_FRAC_BITS +: SW];
		res_r_mag = acc_r_nx[GAIN_FRAC_BITS +: SW];
		res_l     = neg_l_q ? SW'(-res_l_mag) : res_l_mag;
		res_r     = neg_r_q ? SW'(-res_r_mag) : res_r_mag;
	end

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q  <= '0;
			fade_out_q <= '0;
			clip_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfe_pkg::CFG_FADE_IN:  fade_in_q  <= cfg_data;
				sfe_pkg::CFG_FADE_OUT: fade_out_q <= cfg_data;
				sfe_pkg::CFG_CLIP:     clip_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_q     <= '0;
			out_valid_q <= 1'b0;
			phase_out_q <= 1'b0;
			do_out_q    <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// set by a finished frame, held while the sink stalls
			out_valid_q <= ((state_q == ST_FIN) && m_free) || (out_valid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					// counter wraps after the last frame or when outside the clip
					frame_q  <= (nxt >= {1'b0, clip_q}) ? '0 : nxt[FRAME_BITS-1:0];
					do_out_q <= do_out;
					cnt_q    <= '0;
					if (do_in) begin
						phase_out_q <= 1'b0;
						state_q     <= ST_DIV;
					end else if (do_out) begin
						phase_out_q <= 1'b1;
						state_q     <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					cnt_q <= last_bit ? '0 : cnt_q + 1'b1;
					if (last_bit)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= last_bit ? '0 : cnt_q + 1'b1;
					if (last_bit) begin
						if (!phase_out_q && do_out_q) begin
							// overlap: run the fade-out ramp on the faded word
							phase_out_q <= 1'b1;
							state_q     <= ST_DIV;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (m_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					left_q  <= s_tdata[SW-1:0];
					right_q <= s_tdata[2*SW-1:SW];
				end
			end
			ST_PREP: begin
				diff_q <= diff;
				if (do_in) begin
					rem_q <= {1'b0, frame_q};
					den_q <= fade_in_q;
				end else begin
					rem_q <= {1'b0, diff};
					den_q <= fade_out_q;
				end
			end
			ST_DIV: begin
				rem_q  <= {div_rem, 1'b0};
				gain_q <= {gain_q[GW-2:0], div_ge};
				if (last_bit) begin
					mag_l_q <= left_q[SW-1] ? SW'(-left_q) : left_q;
					mag_r_q <= right_q[SW-1] ? SW'(-right_q) : right_q;
					neg_l_q <= left_q[SW-1];
					neg_r_q <= right_q[SW-1];
					acc_l_q <= '0;
					acc_r_q <= '0;
				end
			end
			ST_MUL: begin
				acc_l_q <= acc_l_nx;
				acc_r_q <= acc_r_nx;
				gain_q  <= {1'b0, gain_q[GW-1:1]};
				if (last_bit) begin
					left_q  <= res_l;
					right_q <= res_r;
					rem_q   <= {1'b0, diff_q};
					den_q   <= fade_out_q;
				end
			end
			ST_FIN: begin
				if (m_free)
					out_data_q <= {right_q, left_q};
			end
			default: ;
		endcase
	end

endmodule

[hdl/sfe_checker.sv]
module sfe_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [sfe_pkg::WORD_W-1:0] m_tdata
);

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped or changed under stall");

	// one frame in flight: input closes right after a word is taken
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a frame is in flight");

	// a result does not rise right after a word is taken, while prep still runs
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// input reopens only with the output register filled
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready ##1 s_tready |-> m_tvalid || $past(m_tvalid && m_tready))
		else $error("input reopened without a result");

endmodule

bind stereo_linear_fade_envelope sfe_checker u_sfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
